FILE: hw/rtl/bdbs_pkg.sv
// shared types, codes and address constants of the bus decoder
package bdbs_pkg;

    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned MADDR_W = 17;
    localparam int unsigned POFF_W  = 4;
    localparam int unsigned SND_W   = 7;
    localparam int unsigned BANK_W  = 2;
    localparam int unsigned NIB_W   = 4;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [ADDR_W-1:0] ADDR_PF_LO    = 16'h0100;
    localparam logic [ADDR_W-1:0] ADDR_PF_HI    = 16'h010F;
    localparam logic [ADDR_W-1:0] ADDR_POWER    = 16'h0111;
    localparam logic [ADDR_W-1:0] ADDR_SOUND    = 16'h0115;
    localparam logic [ADDR_W-1:0] ADDR_ID       = 16'h0116;
    localparam logic [ADDR_W-1:0] ADDR_BANK     = 16'h0119;
    localparam logic [ADDR_W-1:0] ADDR_CLKCTL   = 16'h011A;
    localparam logic [ADDR_W-1:0] ADDR_LCDC     = 16'h011E;
    localparam logic [ADDR_W-1:0] ADDR_LCDD     = 16'h011F;
    localparam logic [ADDR_W-1:0] ADDR_RAM_HI   = 16'hCFFF;
    localparam logic [ADDR_W-1:0] ADDR_ROM_LO   = 16'hD000;
    localparam logic [ADDR_W-1:0] ADDR_ROM_HI   = 16'hEFFF;
    localparam logic [ADDR_W-1:0] ADDR_BLOCK_LO = 16'hF800;

    localparam logic [MADDR_W-1:0] ROM_OFFSET = 17'h03000;
    localparam logic [DATA_W-1:0]  ID_VALUE   = 8'h01;
    localparam logic [SND_W-1:0]   SND_HIGH   = 7'h7F;
    localparam logic [SND_W-1:0]   SND_LOW    = 7'h00;

    typedef enum logic [2:0] {
        ROUTE_MEM   = 3'd0,
        ROUTE_PF    = 3'd1,
        ROUTE_LCDC  = 3'd2,
        ROUTE_LCDD  = 3'd3,
        ROUTE_LOCAL = 3'd4,
        ROUTE_POWER = 3'd5,
        ROUTE_SOUND = 3'd6,
        ROUTE_BLOCK = 3'd7
    } t_route;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_byte;
    } t_req;

    typedef struct packed {
        t_route             route;
        logic [MADDR_W-1:0] mem_address;
        logic               mem_enable;
        logic [POFF_W-1:0]  peripheral_offset;
        logic [DATA_W-1:0]  local_read_data;
        logic               cpu_reset_assert;
        logic [SND_W-1:0]   sound_level;
    } t_rsp;

    typedef struct packed {
        logic [BANK_W-1:0] rom_bank;
        logic [NIB_W-1:0]  bank_latch;
        logic [NIB_W-1:0]  clock_control;
    } t_state;

    typedef struct packed {
        logic              bank_we;
        logic              clkctl_we;
        logic [DATA_W-1:0] data;
    } t_state_upd;

endpackage

FILE: hw/rtl/bdbs_req_if.sv
// request channel carrying one cpu bus access
interface bdbs_req_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [bdbs_pkg::ADDR_W-1:0]    bus_address;
    logic [bdbs_pkg::DATA_W-1:0]    write_byte;

    modport source (output valid, output cmd, output bus_address, output write_byte,
                    input ready);
    modport sink   (input valid, input cmd, input bus_address, input write_byte,
                    output ready);
endinterface

FILE: hw/rtl/bdbs_rsp_if.sv
// result channel carrying one decoded access
interface bdbs_rsp_if;
    logic                           valid;
    logic                           ready;
    bdbs_pkg::t_route               route;
    logic [bdbs_pkg::MADDR_W-1:0]   mem_address;
    logic                           mem_enable;
    logic [bdbs_pkg::POFF_W-1:0]    peripheral_offset;
    logic [bdbs_pkg::DATA_W-1:0]    local_read_data;
    logic                           cpu_reset_assert;
    logic [bdbs_pkg::SND_W-1:0]     sound_level;

    modport source (output valid, output route, output mem_address, output mem_enable,
                    output peripheral_offset, output local_read_data,
                    output cpu_reset_assert, output sound_level, input ready);
    modport sink   (input valid, input route, input mem_address, input mem_enable,
                    input peripheral_offset, input local_read_data,
                    input cpu_reset_assert, input sound_level, output ready);
endinterface

FILE: hw/rtl/bdbs_state.sv
// local register file: rom bank, bank latch and clock control
module bdbs_state (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  bdbs_pkg::t_state_upd i_upd,
    output bdbs_pkg::t_state     o_state
);

    bdbs_pkg::t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_en) begin
            if (i_upd.bank_we) begin
                r_state.rom_bank   <= i_upd.data[bdbs_pkg::BANK_W-1:0];
                r_state.bank_latch <= i_upd.data[bdbs_pkg::NIB_W-1:0];
            end
            if (i_upd.clkctl_we) begin
                r_state.clock_control <= i_upd.data[bdbs_pkg::NIB_W-1:0];
            end
        end
    end

    assign o_state = r_state;

endmodule

FILE: hw/rtl/bdbs_decode.sv
// address decode and rom bank translation for one access
module bdbs_decode (
    input  bdbs_pkg::t_req       i_req,
    input  bdbs_pkg::t_state     i_state,
    output bdbs_pkg::t_rsp       o_rsp,
    output bdbs_pkg::t_state_upd o_upd
);

    logic [bdbs_pkg::ADDR_W-1:0]  a;
    logic [bdbs_pkg::DATA_W-1:0]  d;
    logic                         rom_win;
    logic [bdbs_pkg::MADDR_W-1:0] rom_addr;

    assign a = i_req.bus_address;
    assign d = i_req.write_byte;
    assign rom_win = (a >= bdbs_pkg::ADDR_ROM_LO) && (a <= bdbs_pkg::ADDR_ROM_HI);
    // window base 0xd000 lands at 0x10000, each bank is 0x2000 further on
    assign rom_addr = {1'b0, a} + bdbs_pkg::ROM_OFFSET
                    + {2'b00, i_state.rom_bank, 13'b0};

    always_comb begin
        o_rsp = '0;
        o_rsp.route = bdbs_pkg::ROUTE_MEM;
        o_rsp.mem_address = {1'b0, a};
        o_rsp.local_read_data = '0;
        o_rsp.sound_level = bdbs_pkg::SND_LOW;
        o_upd = '0;
        o_upd.data = d;

        if ((a >= bdbs_pkg::ADDR_PF_LO) && (a <= bdbs_pkg::ADDR_PF_HI)) begin
            o_rsp.route = bdbs_pkg::ROUTE_PF;
            o_rsp.peripheral_offset = a[bdbs_pkg::POFF_W-1:0];
        end else if (i_req.cmd == bdbs_pkg::CMD_WRITE) begin
            if (a == bdbs_pkg::ADDR_POWER) begin
                o_rsp.route = bdbs_pkg::ROUTE_POWER;
                o_rsp.cpu_reset_assert = ~d[0];
            end else if (a == bdbs_pkg::ADDR_SOUND) begin
                o_rsp.route = bdbs_pkg::ROUTE_SOUND;
                o_rsp.sound_level = d[0] ? bdbs_pkg::SND_HIGH : bdbs_pkg::SND_LOW;
            end else if (a == bdbs_pkg::ADDR_BANK) begin
                // bank write also lands in the memory array
                o_rsp.route = bdbs_pkg::ROUTE_LOCAL;
                o_rsp.mem_enable = 1'b1;
                o_upd.bank_we = 1'b1;
            end else if (a == bdbs_pkg::ADDR_CLKCTL) begin
                o_rsp.route = bdbs_pkg::ROUTE_LOCAL;
                o_upd.clkctl_we = 1'b1;
            end else if (a == bdbs_pkg::ADDR_LCDC) begin
                o_rsp.route = bdbs_pkg::ROUTE_LCDC;
            end else if (a == bdbs_pkg::ADDR_LCDD) begin
                o_rsp.route = bdbs_pkg::ROUTE_LCDD;
            end else if (a <= bdbs_pkg::ADDR_RAM_HI) begin
                o_rsp.mem_enable = 1'b1;
            end else if (rom_win) begin
                o_rsp.route = bdbs_pkg::ROUTE_BLOCK;
                o_rsp.mem_address = rom_addr;
            end else if (a >= bdbs_pkg::ADDR_BLOCK_LO) begin
                o_rsp.route = bdbs_pkg::ROUTE_BLOCK;
            end else begin
                o_rsp.mem_enable = 1'b1;
            end
        end else begin
            if (a == bdbs_pkg::ADDR_ID) begin
                o_rsp.route = bdbs_pkg::ROUTE_LOCAL;
                o_rsp.local_read_data = bdbs_pkg::ID_VALUE;
            end else if (a == bdbs_pkg::ADDR_BANK) begin
                o_rsp.route = bdbs_pkg::ROUTE_LOCAL;
                o_rsp.local_read_data = {4'h0, i_state.bank_latch};
            end else if (a == bdbs_pkg::ADDR_CLKCTL) begin
                o_rsp.route = bdbs_pkg::ROUTE_LOCAL;
                o_rsp.local_read_data = {4'h0, i_state.clock_control};
            end else if (a == bdbs_pkg::ADDR_LCDC) begin
                o_rsp.route = bdbs_pkg::ROUTE_LCDC;
            end else if (a == bdbs_pkg::ADDR_LCDD) begin
                o_rsp.route = bdbs_pkg::ROUTE_LCDD;
            end else if (rom_win) begin
                o_rsp.mem_address = rom_addr;
                o_rsp.mem_enable = 1'b1;
            end else begin
                o_rsp.mem_enable = 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/bus_decode_bank_switch_core.sv
// top level of the cpu bus decoder with rom bank switching
// Decodes one cpu bus access per clock, while the result side keeps up, into a
// route code, a 17-bit physical address and a memory enable. A request is taken
// into an input register, decoded against the local registers, and held in a
// result register until taken, so one request is accepted every cycle while the
// result side keeps up. Writes to the bank and clock control registers take effect
// for the very next request.
module bus_decode_bank_switch_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdbs_req_if.sink   i_req,
    bdbs_rsp_if.source o_rsp
);

    logic                 r_in_valid;
    bdbs_pkg::t_req       r_in;
    logic                 r_out_valid;
    bdbs_pkg::t_rsp       r_out;

    bdbs_pkg::t_state     state;
    bdbs_pkg::t_rsp       dec_rsp;
    bdbs_pkg::t_state_upd dec_upd;
    logic                 out_free;
    logic                 advance;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign advance     = r_in_valid && out_free;
    assign i_req.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.cmd         <= i_req.cmd;
            r_in.bus_address <= i_req.bus_address;
            r_in.write_byte  <= i_req.write_byte;
        end
        if (advance) begin
            r_out <= dec_rsp;
        end
    end

    bdbs_decode u_decode (
        .i_req   (r_in),
        .i_state (state),
        .o_rsp   (dec_rsp),
        .o_upd   (dec_upd)
    );

    bdbs_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_upd   (dec_upd),
        .o_state (state)
    );

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.route             = r_out.route;
    assign o_rsp.mem_address       = r_out.mem_address;
    assign o_rsp.mem_enable        = r_out.mem_enable;
    assign o_rsp.peripheral_offset = r_out.peripheral_offset;
    assign o_rsp.local_read_data   = r_out.local_read_data;
    assign o_rsp.cpu_reset_assert  = r_out.cpu_reset_assert;
    assign o_rsp.sound_level       = r_out.sound_level;

    // a blocked access never reaches the memory array
    a_block_no_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.route == bdbs_pkg::ROUTE_BLOCK)) |-> !o_rsp.mem_enable)
        else $error("blocked access drives mem_enable");

    a_reset_on_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.cpu_reset_assert) |-> (o_rsp.route == bdbs_pkg::ROUTE_POWER))
        else $error("cpu reset outside a power write");

    a_sound_on_sound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.sound_level != '0))
        |-> (o_rsp.route == bdbs_pkg::ROUTE_SOUND))
        else $error("sound level outside a sound write");

    // bank write must be visible to the next decoded request
    a_bank_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && dec_upd.bank_we)
        |=> (state.rom_bank == $past(dec_upd.data[bdbs_pkg::BANK_W-1:0])))
        else $error("rom bank not updated by bank write");

endmodule

FILE: dv/tb.sv
// self-checking testbench for the bus decoder with rom bank switching
module tb;
    import bdbs_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam logic [MADDR_W-1:0] ROM_BANK_SPAN = 17'h02000;

    logic clk;
    logic rst_n;

    bdbs_req_if bus_req ();
    bdbs_rsp_if dec_rsp ();

    bus_decode_bank_switch_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (bus_req),
        .o_rsp   (dec_rsp)
    );

    // predicted copy of the decoder registers, plus the last power write bit
    logic [BANK_W-1:0] bank_q   = '0;
    logic [NIB_W-1:0]  latch_q  = '0;
    logic [NIB_W-1:0]  clkctl_q = '0;
    logic              pwr_q    = 1'b1;

    t_rsp expected_decodes[$];
    int   mismatch_count = 0;
    int   stall_cycles   = 0;
    bit   src_idle_en    = 1'b1;
    bit   sink_idle_en   = 1'b1;
    bit   hold_go        = 1'b0;

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [MADDR_W-1:0] rom_address(input logic [ADDR_W-1:0] addr);
        return MADDR_W'(addr) + ROM_OFFSET + MADDR_W'(bank_q) * ROM_BANK_SPAN;
    endfunction

    function automatic t_rsp decode_access(input t_req r);
        t_rsp o;
        logic rom_win;
        o = '0;
        o.route = ROUTE_MEM;
        o.mem_address = MADDR_W'(r.bus_address);
        rom_win = (r.bus_address >= ADDR_ROM_LO) && (r.bus_address <= ADDR_ROM_HI);
        if (r.bus_address >= ADDR_PF_LO && r.bus_address <= ADDR_PF_HI) begin
            o.route = ROUTE_PF;
            o.peripheral_offset = POFF_W'(r.bus_address - ADDR_PF_LO);
        end else if (r.cmd == CMD_WRITE) begin
            case (r.bus_address)
                ADDR_POWER: begin
                    o.route = ROUTE_POWER;
                    pwr_q = r.write_byte[0];
                    o.cpu_reset_assert = !pwr_q;
                end
                ADDR_SOUND: begin
                    o.route = ROUTE_SOUND;
                    o.sound_level = r.write_byte[0] ? SND_HIGH : SND_LOW;
                end
                ADDR_BANK: begin
                    o.route = ROUTE_LOCAL;
                    bank_q = r.write_byte[BANK_W-1:0];
                    latch_q = r.write_byte[NIB_W-1:0];
                    o.mem_enable = 1'b1;
                end
                ADDR_CLKCTL: begin
                    o.route = ROUTE_LOCAL;
                    clkctl_q = r.write_byte[NIB_W-1:0];
                end
                ADDR_LCDC: o.route = ROUTE_LCDC;
                ADDR_LCDD: o.route = ROUTE_LCDD;
                default: begin
                    if (r.bus_address <= ADDR_RAM_HI) begin
                        o.mem_enable = 1'b1;
                    end else if (rom_win) begin
                        // rom is write protected but still reports the banked address
                        o.route = ROUTE_BLOCK;
                        o.mem_address = rom_address(r.bus_address);
                    end else if (r.bus_address >= ADDR_BLOCK_LO) begin
                        o.route = ROUTE_BLOCK;
                    end else begin
                        o.mem_enable = 1'b1;
                    end
                end
            endcase
        end else begin
            case (r.bus_address)
                ADDR_ID: begin
                    o.route = ROUTE_LOCAL;
                    o.local_read_data = ID_VALUE;
                end
                ADDR_BANK: begin
                    o.route = ROUTE_LOCAL;
                    o.local_read_data = DATA_W'(latch_q);
                end
                ADDR_CLKCTL: begin
                    o.route = ROUTE_LOCAL;
                    o.local_read_data = DATA_W'(clkctl_q);
                end
                ADDR_LCDC: o.route = ROUTE_LCDC;
                ADDR_LCDD: o.route = ROUTE_LCDD;
                default: begin
                    if (rom_win) o.mem_address = rom_address(r.bus_address);
                    o.mem_enable = 1'b1;
                end
            endcase
        end
        return o;
    endfunction

    task automatic check_field(input string name, input longint unsigned exp_val,
                               input longint unsigned act_val);
        if (exp_val != act_val) begin
            mismatch_count++;
            $display("%0t mismatch %s: expected 0x%0h actual 0x%0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    // scoreboard: results are checked before the same edge's request is predicted
    always @(posedge clk) begin
        t_rsp want;
        if (rst_n) begin
            if (dec_rsp.valid && dec_rsp.ready) begin
                if (expected_decodes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t mismatch result: expected none actual route %0d",
                             $time, dec_rsp.route);
                end else begin
                    want = expected_decodes.pop_front();
                    check_field("route", want.route, dec_rsp.route);
                    check_field("mem_address", want.mem_address, dec_rsp.mem_address);
                    check_field("mem_enable", want.mem_enable, dec_rsp.mem_enable);
                    check_field("peripheral_offset", want.peripheral_offset,
                                dec_rsp.peripheral_offset);
                    check_field("local_read_data", want.local_read_data,
                                dec_rsp.local_read_data);
                    check_field("cpu_reset_assert", want.cpu_reset_assert,
                                dec_rsp.cpu_reset_assert);
                    check_field("sound_level", want.sound_level, dec_rsp.sound_level);
                end
            end
            if (bus_req.valid && bus_req.ready) begin
                expected_decodes.push_back(decode_access(
                    {bus_req.cmd, bus_req.bus_address, bus_req.write_byte}));
            end
        end
    end

    always @(posedge clk) begin
        if ((bus_req.valid && bus_req.ready) || (dec_rsp.valid && dec_rsp.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no progress, %0d results pending",
                     $time, expected_decodes.size());
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stall bursts plus a long hold when hold_go toggles
    initial begin : result_sink
        int  stall_left;
        int  hold_left;
        bit  hold_seen;
        stall_left = 0;
        hold_left = 0;
        hold_seen = 1'b0;
        dec_rsp.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go != hold_seen) begin
                hold_seen = hold_go;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                dec_rsp.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                dec_rsp.ready <= 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                dec_rsp.ready <= 1'b0;
            end else begin
                dec_rsp.ready <= 1'b1;
            end
        end
    end

    // valid stays high on return so back-to-back requests need no re-raise
    task automatic drive_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            bus_req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bus_req.valid       <= 1'b1;
        bus_req.cmd         <= cmd;
        bus_req.bus_address <= addr;
        bus_req.write_byte  <= data;
        @(posedge clk);
        while (!bus_req.ready) @(posedge clk);
    endtask

    task automatic wait_for_idle();
        bus_req.valid <= 1'b0;
        while (expected_decodes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            return ADDR_PF_LO + ADDR_W'($urandom_range(0, 31));
        end else if (sel < 50) begin
            case ($urandom_range(0, 7))
                0:       return ADDR_POWER;
                1:       return ADDR_SOUND;
                2:       return ADDR_ID;
                3:       return ADDR_CLKCTL;
                4:       return ADDR_LCDC;
                5:       return ADDR_LCDD;
                default: return ADDR_BANK;
            endcase
        end else if (sel < 70) begin
            return ADDR_W'($urandom_range(ADDR_ROM_LO, ADDR_ROM_HI));
        end else if (sel < 78) begin
            return ADDR_W'($urandom_range(16'hF000, 16'hFFFF));
        end else begin
            return ADDR_W'($urandom_range(0, 16'hFFFF));
        end
    endfunction

    task automatic test_reset_state();
        drive_access(CMD_READ, ADDR_BANK, 8'h00);
        drive_access(CMD_READ, ADDR_CLKCTL, 8'h00);
        drive_access(CMD_READ, ADDR_ROM_LO, 8'h00);
    endtask

    task automatic test_address_map();
        drive_access(CMD_WRITE, 16'h0000, 8'hFF);
        drive_access(CMD_READ, 16'hFFFF, 8'hFF);
        drive_access(CMD_WRITE, 16'hFFFF, 8'h00);
        drive_access(CMD_READ, ADDR_PF_LO, 8'h00);
        drive_access(CMD_WRITE, ADDR_PF_HI, 8'hA5);
        drive_access(CMD_READ, ADDR_ID, 8'h00);
        // id register is read only, a write falls through to memory
        drive_access(CMD_WRITE, ADDR_ID, 8'h3C);
        drive_access(CMD_READ, 16'h0110, 8'h00);
        drive_access(CMD_WRITE, ADDR_LCDC, 8'h81);
        drive_access(CMD_READ, ADDR_LCDD, 8'h00);
        drive_access(CMD_WRITE, 16'hF7FF, 8'h12);
        drive_access(CMD_WRITE, ADDR_BLOCK_LO, 8'h34);
    endtask

    task automatic test_power_sound();
        drive_access(CMD_WRITE, ADDR_POWER, 8'h00);
        // clearing again must assert reset again
        drive_access(CMD_WRITE, ADDR_POWER, 8'hFE);
        drive_access(CMD_WRITE, ADDR_POWER, 8'hFF);
        drive_access(CMD_READ, ADDR_POWER, 8'h00);
        drive_access(CMD_WRITE, ADDR_SOUND, 8'h01);
        drive_access(CMD_WRITE, ADDR_SOUND, 8'hFE);
        drive_access(CMD_READ, ADDR_SOUND, 8'h00);
    endtask

    task automatic test_bank_switching();
        drive_access(CMD_WRITE, ADDR_BANK, 8'hFF);
        drive_access(CMD_READ, ADDR_BANK, 8'h00);
        drive_access(CMD_READ, ADDR_ROM_LO, 8'h00);
        drive_access(CMD_READ, ADDR_ROM_HI, 8'h00);
        drive_access(CMD_WRITE, 16'hE000, 8'h55);
        drive_access(CMD_WRITE, ADDR_CLKCTL, 8'hA5);
        drive_access(CMD_READ, ADDR_CLKCTL, 8'h00);
        wait_for_idle();
    endtask

    task automatic test_backpressure();
        src_idle_en = 1'b0;
        hold_go = !hold_go;
        repeat (40) begin
            drive_access(logic'($urandom_range(0, 1)), pick_address(),
                         DATA_W'($urandom_range(0, 255)));
        end
        wait_for_idle();
        src_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic(input int count, input bit with_idle);
        src_idle_en = with_idle;
        sink_idle_en = with_idle;
        repeat (count) begin
            drive_access(logic'($urandom_range(0, 1)), pick_address(),
                         DATA_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        rst_n               <= 1'b0;
        bus_req.valid       <= 1'b0;
        bus_req.cmd         <= CMD_READ;
        bus_req.bus_address <= '0;
        bus_req.write_byte  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_address_map();
        test_power_sound();
        test_bank_switching();
        test_backpressure();
        test_random_traffic(630, 1'b1);
        test_random_traffic(150, 1'b0);
        wait_for_idle();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
